FILE: hdl/dcf_pkg.sv
package dcf_pkg;

    // frame layout
    localparam int unsigned FRAME_LEN = 9;

    typedef logic [3:0] t_idx;

    localparam t_idx IDX_SOF      = 4'd0;
    localparam t_idx IDX_ID       = 4'd1;
    localparam t_idx IDX_LEFT     = 4'd2;
    localparam t_idx IDX_PAD_L    = 4'd3;
    localparam t_idx IDX_RIGHT    = 4'd4;
    localparam t_idx IDX_PAD_R    = 4'd5;
    localparam t_idx IDX_DIR      = 4'd6;
    localparam t_idx IDX_CRC_LO   = 4'd7;
    localparam t_idx IDX_CRC_HI   = 4'd8;

    localparam logic [7:0] FRAME_SOF = 8'hFF;
    localparam logic [7:0] FRAME_ID  = 8'h07;
    localparam logic [7:0] FRAME_PAD = 8'h00;

    // direction codes
    localparam logic [7:0] DIR_FWD   = 8'b0101_0000;
    localparam logic [7:0] DIR_LEFT  = 8'b0001_0000;
    localparam logic [7:0] DIR_RIGHT = 8'b0100_0000;
    localparam logic [7:0] DIR_BACK  = 8'b0000_0000;

    // crc-16/modbus
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // classified command passed from front to back
    typedef struct packed {
        logic [7:0] sent;
        logic [7:0] dir;
    } t_cmd;

    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: hdl/dcf_if.sv
interface dcf_in_if;
    logic              valid;
    logic              ready;
    logic              forward_held;
    logic              backward_held;
    logic              left_held;
    logic              right_held;
    logic [7:0]        speed;
    logic signed [7:0] front_ir_count;
    logic signed [7:0] rear_ir_count;

    modport source(
        output valid, forward_held, backward_held, left_held, right_held,
               speed, front_ir_count, rear_ir_count,
        input  ready
    );
    modport sink(
        input  valid, forward_held, backward_held, left_held, right_held,
               speed, front_ir_count, rear_ir_count,
        output ready
    );
endinterface

interface dcf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source(output valid, frame_byte, last_byte, input ready);
    modport sink(input valid, frame_byte, last_byte, output ready);
endinterface

FILE: hdl/drive_command_frame_crc16.sv
// an accepted item goes into a queue slot, then its first frame byte loads into the output register
//   when the back end is idle
// output: nine frame bytes per item, one at a time through the one-byte output register;
//   the input side keeps accepting while the queue has room
// reset: i_rst_n synchronous active low clears queue pointers, byte index and output valid
// no clearing pass, the crc restarts at the start byte of every frame
module drive_command_frame_crc16 #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dcf_in_if.sink     i_cmd,
    dcf_out_if.source  o_frame
);

    // front: classify speed gating and direction byte
    logic          push;
    logic          full;
    dcf_pkg::t_cmd front_cmd;

    // queue to back end
    logic          q_valid;
    logic          q_pop;
    dcf_pkg::t_cmd q_cmd;

    dcf_front u_front (
        .i_cmd  (i_cmd),
        .i_full (full),
        .o_push (push),
        .o_cmd  (front_cmd)
    );

    // short command queue decouples input acceptance from frame emission
    dcf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    // back: serialize nine bytes, running crc over bytes one to six
    dcf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_cmd),
        .o_pop   (q_pop),
        .o_frame (o_frame)
    );

endmodule

FILE: hdl/dcf_front.sv
module dcf_front (
    dcf_in_if.sink          i_cmd,
    input  logic            i_full,
    output logic            o_push,
    output dcf_pkg::t_cmd   o_cmd
);

    logic front_ok;
    logic rear_ok;
    logic speed_on;

    assign front_ok = (i_cmd.front_ir_count > 8'sd0);
    assign rear_ok  = (i_cmd.rear_ir_count > 8'sd0);
    assign speed_on = i_cmd.left_held || i_cmd.right_held
                   || (i_cmd.forward_held && front_ok)
                   || (i_cmd.backward_held && rear_ok);

    assign i_cmd.ready = !i_full;
    assign o_push      = i_cmd.valid && !i_full;

    // direction priority: forward, left, right, backward, else forward
    always_comb begin
        o_cmd.sent = speed_on ? i_cmd.speed : 8'h00;
        priority if (i_cmd.forward_held) begin
            o_cmd.dir = dcf_pkg::DIR_FWD;
        end else if (i_cmd.left_held) begin
            o_cmd.dir = dcf_pkg::DIR_LEFT;
        end else if (i_cmd.right_held) begin
            o_cmd.dir = dcf_pkg::DIR_RIGHT;
        end else if (i_cmd.backward_held) begin
            o_cmd.dir = dcf_pkg::DIR_BACK;
        end else begin
            o_cmd.dir = dcf_pkg::DIR_FWD;
        end
    end

endmodule

FILE: hdl/dcf_queue.sv
module dcf_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dcf_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output dcf_pkg::t_cmd o_data
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    dcf_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count out of range");

endmodule

FILE: hdl/dcf_back.sv
module dcf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  dcf_pkg::t_cmd i_cmd,
    output logic          o_pop,
    dcf_out_if.source     o_frame
);

    logic               load;
    dcf_pkg::t_idx      r_idx, n_idx;
    logic [15:0]        r_crc, n_crc;
    logic [7:0]         cur_byte;
    logic               r_valid, n_valid;
    logic [7:0]         r_byte;
    logic               r_last;

    assign load  = i_valid && (!r_valid || o_frame.ready);
    assign o_pop = load && (r_idx == dcf_pkg::IDX_CRC_HI);

    always_comb begin
        unique case (r_idx)
            dcf_pkg::IDX_SOF:    cur_byte = dcf_pkg::FRAME_SOF;
            dcf_pkg::IDX_ID:     cur_byte = dcf_pkg::FRAME_ID;
            dcf_pkg::IDX_LEFT:   cur_byte = i_cmd.sent;
            dcf_pkg::IDX_PAD_L:  cur_byte = dcf_pkg::FRAME_PAD;
            dcf_pkg::IDX_RIGHT:  cur_byte = i_cmd.sent;
            dcf_pkg::IDX_PAD_R:  cur_byte = dcf_pkg::FRAME_PAD;
            dcf_pkg::IDX_DIR:    cur_byte = i_cmd.dir;
            dcf_pkg::IDX_CRC_LO: cur_byte = r_crc[7:0];
            dcf_pkg::IDX_CRC_HI: cur_byte = r_crc[15:8];
            default:             cur_byte = dcf_pkg::FRAME_PAD;
        endcase
    end

    always_comb begin
        n_idx   = r_idx;
        n_crc   = r_crc;
        n_valid = r_valid && !o_frame.ready;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = (r_idx == dcf_pkg::IDX_CRC_HI) ? dcf_pkg::IDX_SOF : r_idx + 1'b1;
            if (r_idx == dcf_pkg::IDX_SOF) begin
                n_crc = dcf_pkg::CRC_INIT;
            end else if (r_idx <= dcf_pkg::IDX_DIR) begin
                n_crc = dcf_pkg::crc_byte(r_crc, cur_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= dcf_pkg::IDX_SOF;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
        if (load) begin
            r_byte <= cur_byte;
            r_last <= (r_idx == dcf_pkg::IDX_CRC_HI);
        end
    end

    assign o_frame.valid      = r_valid;
    assign o_frame.frame_byte = r_byte;
    assign o_frame.last_byte  = r_last;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= dcf_pkg::IDX_CRC_HI)
        else $error("byte index out of range");
    a_last_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_valid && r_last))
        else $error("frame end without last byte flag");
    a_sof_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_idx == dcf_pkg::IDX_SOF) |=> (r_byte == dcf_pkg::FRAME_SOF && !r_last))
        else $error("frame does not open with start byte");

endmodule

FILE: test/drive_command_frame_crc16_tb.sv
`timescale 1ns / 100ps

module drive_command_frame_crc16_tb;

    // one drive command as offered on the input channel
    typedef struct packed {
        logic              fwd;
        logic              back;
        logic              lft;
        logic              rgt;
        logic [7:0]        speed;
        logic signed [7:0] front_cnt;
        logic signed [7:0] rear_cnt;
    } t_drive_cmd;

    // one predicted byte of the wheel command frame
    typedef struct {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_frame_byte;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dcf_in_if  cmd_if();
    dcf_out_if frame_if();

    drive_command_frame_crc16 u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_frame (frame_if)
    );

    always #10 i_clk = ~i_clk;

    // commands waiting to be offered, head is the one on the bus while valid is high
    t_drive_cmd  pending_cmds[$];
    // frame bytes still owed by the block, oldest first
    t_frame_byte owed_bytes[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int cycle_count    = 0;
    int hold_left      = 0;
    logic hold_kick    = 1'b0;
    logic hold_seen    = 1'b0;

    // builds the nine frame bytes for one command and appends them to the owed list
    function automatic void queue_frame_bytes(input t_drive_cmd c);
        logic [7:0]  frame [dcf_pkg::FRAME_LEN];
        logic [7:0]  sent;
        logic [7:0]  dir;
        logic [15:0] crc;
        logic        lsb;
        t_frame_byte fb;
        // speed passes if turning, or if the counter in the travel direction is positive
        if (c.lft || c.rgt || (c.fwd && $signed(c.front_cnt) > 0)
                || (c.back && $signed(c.rear_cnt) > 0))
            sent = c.speed;
        else
            sent = 8'h00;
        // forward wins, then left, right, backward; nothing held falls back to forward
        if (c.fwd)
            dir = dcf_pkg::DIR_FWD;
        else if (c.lft)
            dir = dcf_pkg::DIR_LEFT;
        else if (c.rgt)
            dir = dcf_pkg::DIR_RIGHT;
        else if (c.back)
            dir = dcf_pkg::DIR_BACK;
        else
            dir = dcf_pkg::DIR_FWD;
        frame[dcf_pkg::IDX_SOF]   = dcf_pkg::FRAME_SOF;
        frame[dcf_pkg::IDX_ID]    = dcf_pkg::FRAME_ID;
        frame[dcf_pkg::IDX_LEFT]  = sent;
        frame[dcf_pkg::IDX_PAD_L] = dcf_pkg::FRAME_PAD;
        frame[dcf_pkg::IDX_RIGHT] = sent;
        frame[dcf_pkg::IDX_PAD_R] = dcf_pkg::FRAME_PAD;
        frame[dcf_pkg::IDX_DIR]   = dir;
        // modbus crc, reflected, over the id byte through the direction byte
        crc = dcf_pkg::CRC_INIT;
        for (int i = dcf_pkg::IDX_ID; i <= dcf_pkg::IDX_DIR; i++) begin
            crc = crc ^ {8'h00, frame[i]};
            for (int b = 0; b < 8; b++) begin
                lsb = crc[0];
                crc = crc >> 1;
                if (lsb)
                    crc = crc ^ dcf_pkg::CRC_POLY;
            end
        end
        frame[dcf_pkg::IDX_CRC_LO] = crc[7:0];
        frame[dcf_pkg::IDX_CRC_HI] = crc[15:8];
        for (int k = 0; k < dcf_pkg::FRAME_LEN; k++) begin
            fb.frame_byte = frame[k];
            fb.last_byte  = (k == dcf_pkg::FRAME_LEN - 1);
            owed_bytes.push_back(fb);
        end
    endfunction

    function automatic t_drive_cmd make_cmd(input logic f, input logic bk, input logic l,
                                            input logic r, input logic [7:0] spd,
                                            input logic signed [7:0] fc,
                                            input logic signed [7:0] rc);
        t_drive_cmd c;
        c.fwd       = f;
        c.back      = bk;
        c.lft       = l;
        c.rgt       = r;
        c.speed     = spd;
        c.front_cnt = fc;
        c.rear_cnt  = rc;
        return c;
    endfunction

    // counters lean toward the sign boundary and the extremes now and then
    function automatic logic [7:0] random_counter();
        logic [7:0] edges [5];
        edges = '{8'h80, 8'hFF, 8'h00, 8'h01, 8'h7F};
        if ($urandom_range(3) == 0)
            return edges[$urandom_range(4)];
        return 8'($urandom_range(255));
    endfunction

    function automatic t_drive_cmd random_cmd();
        t_drive_cmd c;
        logic [3:0] btn;
        // half the time a single button or none, otherwise any mix
        if ($urandom_range(1) == 0)
            btn = 4'($urandom_range(15));
        else
            btn = 4'(($urandom_range(4) == 4) ? 0 : (1 << $urandom_range(3)));
        c = make_cmd(btn[3], btn[2], btn[1], btn[0], 8'($urandom_range(255)),
                     random_counter(), random_counter());
        return c;
    endfunction

    // sender side: wait for every owed byte to come back before moving on
    task automatic wait_frames_drained();
        while (pending_cmds.size() != 0 || owed_bytes.size() != 0)
            @(negedge i_clk);
    endtask

    // driver: holds an item until it is taken, then offers the next one or idles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready)
                queue_frame_bytes(pending_cmds.pop_front());
            if (!cmd_if.valid || cmd_if.ready) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cmd_if.valid          <= 1'b1;
                    cmd_if.forward_held   <= pending_cmds[0].fwd;
                    cmd_if.backward_held  <= pending_cmds[0].back;
                    cmd_if.left_held      <= pending_cmds[0].lft;
                    cmd_if.right_held     <= pending_cmds[0].rgt;
                    cmd_if.speed          <= pending_cmds[0].speed;
                    cmd_if.front_ir_count <= pending_cmds[0].front_cnt;
                    cmd_if.rear_ir_count  <= pending_cmds[0].rear_cnt;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off whenever the kick toggles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_if.ready <= 1'b0;
        end else if (hold_kick != hold_seen) begin
            hold_seen      <= hold_kick;
            hold_left      <= HOLD_CYCLES;
            frame_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left      <= hold_left - 1;
            frame_if.ready <= 1'b0;
        end else begin
            frame_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: every accepted byte must match the oldest owed one
    always @(posedge i_clk) begin
        if (i_rst_n && frame_if.valid && frame_if.ready) begin
            if (owed_bytes.size() == 0) begin
                mismatches <= mismatches + 1;
                $display("%0t: unexpected frame byte %02h last %0b", $time,
                         frame_if.frame_byte, frame_if.last_byte);
            end else begin
                if (frame_if.frame_byte !== owed_bytes[0].frame_byte
                        || frame_if.last_byte !== owed_bytes[0].last_byte) begin
                    mismatches <= mismatches + 1;
                    $display("%0t: frame byte expected %02h last %0b, got %02h last %0b",
                             $time, owed_bytes[0].frame_byte, owed_bytes[0].last_byte,
                             frame_if.frame_byte, frame_if.last_byte);
                end
                void'(owed_bytes.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        i_rst_n               = 1'b0;
        cmd_if.valid          = 1'b0;
        cmd_if.forward_held   = 1'b0;
        cmd_if.backward_held  = 1'b0;
        cmd_if.left_held      = 1'b0;
        cmd_if.right_held     = 1'b0;
        cmd_if.speed          = 8'h00;
        cmd_if.front_ir_count = 8'sh00;
        cmd_if.rear_ir_count  = 8'sh00;
        frame_if.ready        = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: every button mix, speed and counter extremes
        for (int b = 0; b < 16; b++) begin
            pending_cmds.push_back(make_cmd(b[3], b[2], b[1], b[0],
                                   (b % 2 == 0) ? 8'hFF : 8'h00,
                                   (b % 4 < 2) ? 8'sh7F : 8'sh80,
                                   (b % 3 == 0) ? 8'sh01 : 8'shFF));
        end
        // forward alone: zero and negative front counter block the speed
        pending_cmds.push_back(make_cmd(1'b1, 1'b0, 1'b0, 1'b0, 8'hA5, 8'sh00, 8'sh7F));
        pending_cmds.push_back(make_cmd(1'b1, 1'b0, 1'b0, 1'b0, 8'h5A, 8'sh01, 8'sh00));
        pending_cmds.push_back(make_cmd(1'b1, 1'b0, 1'b0, 1'b0, 8'hFF, 8'shFF, 8'sh01));
        // backward alone: rear counter at the sign boundary
        pending_cmds.push_back(make_cmd(1'b0, 1'b1, 1'b0, 1'b0, 8'hA5, 8'sh7F, 8'sh00));
        pending_cmds.push_back(make_cmd(1'b0, 1'b1, 1'b0, 1'b0, 8'h5A, 8'sh00, 8'sh01));
        pending_cmds.push_back(make_cmd(1'b0, 1'b1, 1'b0, 1'b0, 8'hFF, 8'sh01, 8'sh80));
        // forward and backward together: either counter may pass the speed
        pending_cmds.push_back(make_cmd(1'b1, 1'b1, 1'b0, 1'b0, 8'h3C, 8'sh80, 8'sh7F));
        pending_cmds.push_back(make_cmd(1'b1, 1'b1, 1'b0, 1'b0, 8'hC3, 8'sh00, 8'sh00));
        wait_frames_drained();

        // random phases: no idling, sender idle, receiver stalling, both
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1) ? 46 : (phase == 3) ? 21 : 0;
            recv_stall_pct = (phase == 2) ? 46 : (phase == 3) ? 21 : 0;
            for (int n = 0; n < 120; n++)
                pending_cmds.push_back(random_cmd());
            wait_frames_drained();
        end

        // long receiver hold-off while the sender keeps offering, so the input backs up
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_kick      = ~hold_kick;
        for (int n = 0; n < 30; n++)
            pending_cmds.push_back(random_cmd());
        wait_frames_drained();

        // let any stray bytes surface before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
